### design/positional_list_store_unit_defines.svh
// assertion macros shared by the checker of the list store
`ifndef POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH

// property that must hold in the cycle after the trigger, outside reset
`define PLSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list store check failed");

// property that must hold in the same cycle, outside reset
`define PLSU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list store check failed");

// property that also covers the reset cycles
`define PLSU_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("list store check failed");

`endif

### design/plsu_pkg.sv
package plsu_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned LEN_W        = 5;
  localparam int unsigned CAPACITY_DEF = 16;

  // command codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // broadcast control for the row of cells
  typedef struct packed {
    logic                     shift_up;
    logic                     shift_down;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

### design/plsu_cell.sv
module plsu_cell import plsu_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  output logic signed [DATA_W-1:0] q
);

  localparam logic [31:0] IDX = 32'(INDEX);

  logic [31:0] pos_ext;

  assign pos_ext = 32'(ctl.pos);

  // insert takes the lower neighbour above the position, remove the upper one
  always_ff @(posedge clk) begin
    if (ctl.shift_up) begin
      if (IDX > pos_ext) begin
        q <= left;
      end else if (IDX == pos_ext) begin
        q <= ctl.value;
      end
    end else if (ctl.shift_down) begin
      if (IDX >= pos_ext) begin
        q <= right;
      end
    end
  end

endmodule

### design/positional_list_store_unit.sv
// result strobe (done): registered, high in the cycle after an accepted command
// throughput: one command per cycle; busy stays low, every cell of the row
// compares its own index with the position and shifts in that same cycle
// the receiver cannot stall, so each result is shown for exactly one cycle
// reset: list length cleared to zero, done low; entry contents undefined
module positional_list_store_unit import plsu_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          opcode,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output logic                     done,
  output logic                     ok,
  output logic signed [DATA_W-1:0] read_value,
  output logic [LEN_W-1:0]         length
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     accept;
  op_t                      op;
  logic [CNT_W+POS_W-1:0]   pos_c;
  logic [CNT_W+POS_W-1:0]   cnt_c;
  logic [IDX_W+POS_W-1:0]   pos_wide;
  logic [IDX_W-1:0]         sel;
  logic [LEN_W+CNT_W-1:0]   len_ext;
  logic                     in_range;
  logic                     ins_range;
  logic                     full;
  logic                     ok_next;
  logic signed [DATA_W-1:0] rd_next;
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] cell_q [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = op_t'(opcode);

  // range checks against the current length
  assign pos_c     = {{CNT_W{1'b0}}, position};
  assign cnt_c     = {{POS_W{1'b0}}, count};
  assign in_range  = pos_c < cnt_c;
  assign ins_range = pos_c <= cnt_c;
  assign full      = count == CNT_W'(CAPACITY);
  assign pos_wide  = {{IDX_W{1'b0}}, position};
  assign sel       = pos_wide[IDX_W-1:0];
  assign len_ext   = {{LEN_W{1'b0}}, count_next};

  // command decode
  always_comb begin
    ctl.shift_up   = 1'b0;
    ctl.shift_down = 1'b0;
    ctl.pos        = position;
    ctl.value      = value;
    ok_next        = 1'b0;
    rd_next        = '0;
    count_next     = count;
    if (accept) begin
      unique case (op)
        OP_INSERT: begin
          if (ins_range && !full) begin
            ctl.shift_up = 1'b1;
            count_next   = count + CNT_W'(1);
            ok_next      = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (in_range) begin
            ctl.shift_down = 1'b1;
            count_next     = count - CNT_W'(1);
            ok_next        = 1'b1;
          end
        end
        OP_READ: begin
          if (in_range) begin
            rd_next = cell_q[sel];
            ok_next = 1'b1;
          end
        end
        OP_CLEAR: begin
          count_next = '0;
          ok_next    = 1'b1;
        end
        default: begin
          ok_next = 1'b0;
        end
      endcase
    end
  end

  // row of cells linked to their neighbours; value feeds the first, the last reads itself
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = value;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    plsu_cell #(
      .INDEX(i)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .left  (left_d),
      .right (right_d),
      .q     (cell_q[i])
    );
  end

  // length and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    ok         <= ok_next;
    read_value <= rd_next;
    length     <= len_ext[LEN_W-1:0];
  end

endmodule

### design/plsu_checker.sv
`include "positional_list_store_unit_defines.svh"

module plsu_checker import plsu_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic [OP_W-1:0]          opcode,
  input logic                     done,
  input logic                     ok,
  input logic signed [DATA_W-1:0] read_value,
  input logic [LEN_W-1:0]         length
);

  // every accepted command gives exactly one result word in the next cycle
  `PLSU_ASSERT_NEXT(a_result_follows, start && !busy, done)
  `PLSU_ASSERT_NEXT(a_no_spurious, !(start && !busy), !done)
  // clear always succeeds and empties the list
  `PLSU_ASSERT_NEXT(a_clear_empties, start && !busy && opcode == OP_CLEAR,
                    ok && length == '0)
  // a rejected command never returns data
  `PLSU_ASSERT_NOW(a_fail_zero, done && !ok, read_value == '0)
  // no result word straight after reset
  `PLSU_ASSERT_ALWAYS(a_reset_quiet, rst, !done)

endmodule

bind positional_list_store_unit plsu_checker u_plsu_checker (.*);
